FILE: rtl/sora_pkg.sv
// Shared constants, types and helper functions for the sparse observation row assembler.
package sora_pkg;

    localparam int MAX_ROWS        = 16;
    localparam int ENTRIES_PER_ROW = 8;
    localparam int PARAM_COLUMNS   = 1024;

    localparam int ROW_IDX_W   = $clog2(MAX_ROWS);
    localparam int SLOT_IDX_W  = $clog2(ENTRIES_PER_ROW);
    localparam int ENTRY_DEPTH = MAX_ROWS * ENTRIES_PER_ROW;
    localparam int ENTRY_AW    = $clog2(ENTRY_DEPTH);
    localparam int COL_W       = $clog2(PARAM_COLUMNS);
    localparam int COUNT_W     = $clog2(ENTRIES_PER_ROW + 1);
    localparam int COV_SIZE    = (MAX_ROWS * (MAX_ROWS + 1)) / 2;
    localparam int COV_AW      = $clog2(COV_SIZE);

    // Port field widths.
    localparam int OP_W       = 2;
    localparam int ROW_W      = 5;
    localparam int COLUMN_W   = 11;
    localparam int SLOT_W     = 3;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int AFTER_W    = 4;
    localparam int ELT_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_COV   = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DIAG_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'b1;

    typedef struct packed {
        logic [COL_W-1:0]          col;
        logic signed [VALUE_W-1:0] val;
    } entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic                      merged;
        logic [SLOT_W-1:0]         slot_used;
        logic [AFTER_W-1:0]        entries_after;
        logic signed [VALUE_W-1:0] value_out;
        logic [COLUMN_W-1:0]       column_out;
        logic [ELT_W-1:0]          element_index;
    } res_t;

    // Packed lower-triangle position of element (hi, lo) with hi >= lo.
    function automatic logic [COV_AW-1:0] tri_index(input logic [ROW_IDX_W-1:0] hi,
                                                    input logic [ROW_IDX_W-1:0] lo);
        logic [2*ROW_IDX_W-1:0] prod;
        prod = {{ROW_IDX_W{1'b0}}, hi} * ({{ROW_IDX_W{1'b0}}, hi} + (2*ROW_IDX_W)'(1));
        return COV_AW'((prod >> 1) + {{ROW_IDX_W{1'b0}}, lo});
    endfunction

endpackage

FILE: rtl/sparse_observation_row_assembler_unit.sv
// Top level: sequencer for the sparse observation row assembler.
//
//  Channel   | Signals                                             | Handshake
//  ----------+-----------------------------------------------------+---------------------------
//  command   | op, row, other_row, column, slot, value             | taken when start && !busy
//  result    | status, merged, slot_used, entries_after,           | done high for one cycle
//            | value_out, column_out, element_index                |
//  config    | cfg_we, cfg_index, cfg_data                         | written when cfg_we high
//
// An item occupies the sequencer from acceptance until its result appears on done: a
// covariance write takes decode; a read, decode and read; an add, decode, a scan of the stored
// columns (one compared per cycle through the single entry memory read port) and write-back;
// a clear, decode and a pass zeroing one covariance element per cycle. A read or add refused
// at decode, and an add to an empty row, end in decode. After reset a clearing pass runs with
// busy high. Results cannot be held off; the next item may be taken while done is high.
module sparse_observation_row_assembler_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [sora_pkg::OP_W-1:0]              op,
    input  logic [sora_pkg::ROW_W-1:0]             row,
    input  logic [sora_pkg::ROW_W-1:0]             other_row,
    input  logic [sora_pkg::COLUMN_W-1:0]          column,
    input  logic [sora_pkg::SLOT_W-1:0]            slot,
    input  logic signed [sora_pkg::VALUE_W-1:0]    value,
    input  logic                                   cfg_we,
    input  logic [sora_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [sora_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic                                   done,
    output logic [sora_pkg::STATUS_W-1:0]          status,
    output logic                                   merged,
    output logic [sora_pkg::SLOT_W-1:0]            slot_used,
    output logic [sora_pkg::AFTER_W-1:0]           entries_after,
    output logic signed [sora_pkg::VALUE_W-1:0]    value_out,
    output logic [sora_pkg::COLUMN_W-1:0]          column_out,
    output logic [sora_pkg::ELT_W-1:0]             element_index
);
    import sora_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_SCAN   = 6'b000100,
        S_ACCUM  = 6'b001000,
        S_READ   = 6'b010000,
        S_CLEAR  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic [ROW_W-1:0]          row_reg, row_next;
    logic [ROW_W-1:0]          orow_reg, orow_next;
    logic [COLUMN_W-1:0]       col_reg, col_next;
    logic [SLOT_W-1:0]         slot_reg, slot_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic                      diag_reg;
    logic [CFG_DATA_W-1:0]     rows_reg;
    logic [COUNT_W-1:0]        counts_reg [MAX_ROWS];
    logic [COUNT_W-1:0]        counts_next [MAX_ROWS];
    logic [COUNT_W-1:0]        cnt_reg, cnt_next;
    logic [SLOT_IDX_W-1:0]     idx_reg, idx_next;
    logic [COV_AW-1:0]         clr_idx_reg, clr_idx_next;
    logic                      clr_report_reg, clr_report_next;
    logic                      done_reg, done_next;
    res_t                      res_reg, res_next;

    logic [ROW_W-1:0]          nr;
    logic                      row_ok, orow_ok, col_ok;
    logic [ROW_W-1:0]          row_m1, orow_m1;
    logic [COLUMN_W-1:0]       col_m1;
    logic [ROW_IDX_W-1:0]      r_idx, o_idx, hi_idx, lo_idx;
    logic [COL_W-1:0]          key;
    logic [COUNT_W-1:0]        cnt_cur;
    logic [COUNT_W-1:0]        idx_plus;

    logic                      ent_we;
    logic [ENTRY_AW-1:0]       ent_waddr, ent_raddr;
    entry_t                    ent_wdata, ent_rdata;
    logic                      cov_we;
    logic [COV_AW-1:0]         cov_waddr;
    logic signed [VALUE_W-1:0] cov_wdata;
    logic                      alu_match;
    logic signed [VALUE_W-1:0] alu_sum;

    sora_entry_ram u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    sora_cov_ram u_cov_ram (
        .clk   (clk),
        .we    (cov_we),
        .waddr (cov_waddr),
        .wdata (cov_wdata)
    );

    sora_alu u_alu (
        .stored  (ent_rdata),
        .key     (key),
        .addend  (val_reg),
        .match   (alu_match),
        .sum_sat (alu_sum)
    );

    // A row limit of zero behaves as one, and one above the row count as the row count.
    always_comb
    begin
        if (rows_reg == '0)
        begin
            nr = ROW_W'(1);
        end
        else if (rows_reg > ROW_W'(MAX_ROWS))
        begin
            nr = ROW_W'(MAX_ROWS);
        end
        else
        begin
            nr = rows_reg;
        end
    end

    assign row_ok   = (row_reg != '0) && (row_reg <= nr);
    assign orow_ok  = (orow_reg != '0) && (orow_reg <= nr);
    assign col_ok   = (col_reg != '0) && (col_reg <= COLUMN_W'(PARAM_COLUMNS));
    assign row_m1   = row_reg - ROW_W'(1);
    assign orow_m1  = orow_reg - ROW_W'(1);
    assign col_m1   = col_reg - COLUMN_W'(1);
    assign r_idx    = row_m1[ROW_IDX_W-1:0];
    assign o_idx    = orow_m1[ROW_IDX_W-1:0];
    assign hi_idx   = (r_idx > o_idx) ? r_idx : o_idx;
    assign lo_idx   = (r_idx > o_idx) ? o_idx : r_idx;
    assign key      = col_m1[COL_W-1:0];
    assign cnt_cur  = counts_reg[r_idx];
    assign idx_plus = COUNT_W'(idx_reg) + COUNT_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        row_next        = row_reg;
        orow_next       = orow_reg;
        col_next        = col_reg;
        slot_next       = slot_reg;
        val_next        = val_reg;
        counts_next     = counts_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        clr_idx_next    = clr_idx_reg;
        clr_report_next = clr_report_reg;
        done_next       = 1'b0;
        res_next        = res_reg;
        ent_we          = 1'b0;
        ent_waddr       = {r_idx, cnt_reg[SLOT_IDX_W-1:0]};
        ent_wdata       = '{col: key, val: val_reg};
        ent_raddr       = {r_idx, idx_reg};
        cov_we          = 1'b0;
        cov_waddr       = clr_idx_reg;
        cov_wdata       = val_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = op_t'(op);
                    row_next   = row;
                    orow_next  = other_row;
                    col_next   = column;
                    slot_next  = slot;
                    val_next   = value;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                res_next   = '0;
                state_next = S_IDLE;
                unique case (op_reg)
                    OP_CLEAR:
                    begin
                        for (int i = 0; i < MAX_ROWS; i++)
                        begin
                            counts_next[i] = '0;
                        end
                        clr_idx_next    = '0;
                        clr_report_next = 1'b1;
                        state_next      = S_CLEAR;
                    end

                    OP_ADD:
                    begin
                        if (!row_ok)
                        begin
                            res_next.status = ST_RANGE;
                            done_next       = 1'b1;
                        end
                        else if (!col_ok)
                        begin
                            res_next.status        = ST_RANGE;
                            res_next.entries_after = AFTER_W'(cnt_cur);
                            done_next              = 1'b1;
                        end
                        else if (cnt_cur == '0)
                        begin
                            // An empty row cannot hit, so the pair goes straight to slot zero.
                            ent_we                 = 1'b1;
                            ent_waddr              = {r_idx, {SLOT_IDX_W{1'b0}}};
                            counts_next[r_idx]     = COUNT_W'(1);
                            res_next.entries_after = AFTER_W'(1);
                            res_next.value_out     = val_reg;
                            res_next.column_out    = col_reg;
                            done_next              = 1'b1;
                        end
                        else
                        begin
                            cnt_next   = cnt_cur;
                            idx_next   = '0;
                            ent_raddr  = {r_idx, {SLOT_IDX_W{1'b0}}};
                            state_next = S_SCAN;
                        end
                    end

                    OP_COV:
                    begin
                        done_next = 1'b1;
                        if (!row_ok || !orow_ok)
                        begin
                            res_next.status = ST_RANGE;
                        end
                        else
                        begin
                            res_next.entries_after = AFTER_W'(cnt_cur);
                            if (diag_reg)
                            begin
                                // Off-diagonal writes are dropped in diagonal mode.
                                if (r_idx == o_idx)
                                begin
                                    cov_we                 = 1'b1;
                                    cov_waddr              = COV_AW'(r_idx);
                                    res_next.element_index = ELT_W'(r_idx);
                                    res_next.value_out     = val_reg;
                                end
                            end
                            else
                            begin
                                cov_we                 = 1'b1;
                                cov_waddr              = tri_index(hi_idx, lo_idx);
                                res_next.element_index = ELT_W'(tri_index(hi_idx, lo_idx));
                                res_next.value_out     = val_reg;
                            end
                        end
                    end

                    OP_READ:
                    begin
                        if (!row_ok)
                        begin
                            res_next.status = ST_RANGE;
                            done_next       = 1'b1;
                        end
                        else if (COUNT_W'(slot_reg) >= cnt_cur)
                        begin
                            res_next.status        = ST_RANGE;
                            res_next.entries_after = AFTER_W'(cnt_cur);
                            done_next              = 1'b1;
                        end
                        else
                        begin
                            cnt_next   = cnt_cur;
                            ent_raddr  = {r_idx, slot_reg[SLOT_IDX_W-1:0]};
                            state_next = S_READ;
                        end
                    end

                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_SCAN:
            begin
                res_next = '0;
                priority if (alu_match)
                begin
                    // Re-read the same entry so it is still on the read port for the add.
                    ent_raddr  = {r_idx, idx_reg};
                    state_next = S_ACCUM;
                end
                else if (idx_plus == cnt_reg)
                begin
                    res_next.column_out    = col_reg;
                    res_next.entries_after = AFTER_W'(cnt_reg);
                    done_next              = 1'b1;
                    state_next             = S_IDLE;
                    if (cnt_reg == COUNT_W'(ENTRIES_PER_ROW))
                    begin
                        res_next.status = ST_FULL;
                    end
                    else
                    begin
                        ent_we                 = 1'b1;
                        counts_next[r_idx]     = cnt_reg + COUNT_W'(1);
                        res_next.entries_after = AFTER_W'(cnt_reg + COUNT_W'(1));
                        res_next.slot_used     = SLOT_W'(cnt_reg);
                        res_next.value_out     = val_reg;
                    end
                end
                else
                begin
                    idx_next  = idx_reg + SLOT_IDX_W'(1);
                    ent_raddr = {r_idx, idx_plus[SLOT_IDX_W-1:0]};
                end
            end

            S_ACCUM:
            begin
                ent_we                 = 1'b1;
                ent_waddr              = {r_idx, idx_reg};
                ent_wdata              = '{col: key, val: alu_sum};
                res_next               = '0;
                res_next.merged        = 1'b1;
                res_next.slot_used     = SLOT_W'(idx_reg);
                res_next.entries_after = AFTER_W'(cnt_reg);
                res_next.value_out     = alu_sum;
                res_next.column_out    = col_reg;
                done_next              = 1'b1;
                state_next             = S_IDLE;
            end

            S_READ:
            begin
                res_next               = '0;
                res_next.slot_used     = slot_reg;
                res_next.entries_after = AFTER_W'(cnt_reg);
                res_next.value_out     = ent_rdata.val;
                res_next.column_out    = COLUMN_W'(ent_rdata.col) + COLUMN_W'(1);
                done_next              = 1'b1;
                state_next             = S_IDLE;
            end

            S_CLEAR:
            begin
                cov_we    = 1'b1;
                cov_waddr = clr_idx_reg;
                cov_wdata = '0;
                if (clr_idx_reg == COV_AW'(COV_SIZE - 1))
                begin
                    // The pass after reset ends silently; a clear item reports an all-zero item.
                    res_next        = '0;
                    done_next       = clr_report_reg;
                    clr_report_next = 1'b0;
                    state_next      = S_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + COV_AW'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_idx_reg    <= '0;
            clr_report_reg <= 1'b0;
            done_reg       <= 1'b0;
            diag_reg       <= 1'b0;
            rows_reg       <= CFG_DATA_W'(MAX_ROWS);
            for (int i = 0; i < MAX_ROWS; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            clr_report_reg <= clr_report_next;
            done_reg       <= done_next;
            counts_reg     <= counts_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DIAG_MODE:   diag_reg <= cfg_data[0];
                    CFG_ROWS_IN_USE: rows_reg <= cfg_data;
                    default:         diag_reg <= diag_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        row_reg  <= row_next;
        orow_reg <= orow_next;
        col_reg  <= col_next;
        slot_reg <= slot_next;
        val_reg  <= val_next;
        cnt_reg  <= cnt_next;
        idx_reg  <= idx_next;
        res_reg  <= res_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = res_reg.status;
    assign merged        = res_reg.merged;
    assign slot_used     = res_reg.slot_used;
    assign entries_after = res_reg.entries_after;
    assign value_out     = res_reg.value_out;
    assign column_out    = res_reg.column_out;
    assign element_index = res_reg.element_index;

`ifndef ASSERT_OFF
    a_scan_within_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (COUNT_W'(idx_reg) < cnt_reg))
        else $error("scan index reached the row count");

    a_merge_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && res_reg.merged) |-> (res_reg.status == ST_OK))
        else $error("merged item carries a non-ok status");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (res_reg.status == ST_OK || res_reg.status == ST_FULL ||
                      res_reg.status == ST_RANGE))
        else $error("undefined status code on a result");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_DECODE))
        else $error("accepted item did not enter decode");

    a_clear_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (clr_idx_reg < COV_AW'(COV_SIZE)))
        else $error("clearing pass ran past the covariance store");
`endif

endmodule

FILE: rtl/sora_entry_ram.sv
// Entry memory holding the (column, coefficient) pairs of every row.
module sora_entry_ram (
    input  logic                     clk,
    input  logic                     we,
    input  logic [sora_pkg::ENTRY_AW-1:0] waddr,
    input  sora_pkg::entry_t         wdata,
    input  logic [sora_pkg::ENTRY_AW-1:0] raddr,
    output sora_pkg::entry_t         rdata
);
    import sora_pkg::*;

    entry_t mem [ENTRY_DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/sora_cov_ram.sv
// Packed lower-triangular covariance store with a single write port.
module sora_cov_ram (
    input  logic                        clk,
    input  logic                        we,
    input  logic [sora_pkg::COV_AW-1:0] waddr,
    input  logic signed [sora_pkg::VALUE_W-1:0] wdata
);
    import sora_pkg::*;

    logic signed [VALUE_W-1:0] mem [COV_SIZE];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

FILE: rtl/sora_alu.sv
// Shared column comparator and saturating Q16.16 accumulator.
module sora_alu (
    input  sora_pkg::entry_t                    stored,
    input  logic [sora_pkg::COL_W-1:0]          key,
    input  logic signed [sora_pkg::VALUE_W-1:0] addend,
    output logic                                match,
    output logic signed [sora_pkg::VALUE_W-1:0] sum_sat
);
    import sora_pkg::*;

    logic signed [VALUE_W:0] sum_wide;

    assign match    = (stored.col == key);
    assign sum_wide = {stored.val[VALUE_W-1], stored.val} + {addend[VALUE_W-1], addend};

    // The two top bits differ only when the true sum left the 32-bit range.
    always_comb
    begin
        if (sum_wide[VALUE_W] != sum_wide[VALUE_W-1])
        begin
            sum_sat = sum_wide[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                        : {1'b0, {(VALUE_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[VALUE_W-1:0];
        end
    end

endmodule
